// File: rtl/sqh_pkg.sv
`timescale 1ns / 1ps
package sqh_pkg;
	localparam int DEPTH = 1024;
	localparam int COORD_BITS = 7;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int PW = 2 * COORD_BITS;
	localparam int SW = 16;
	localparam int KW = COORD_BITS + 1;

	localparam logic [2:0] V_UNSURE = 3'd0;
	localparam logic [2:0] V_IMPOSSIBLE = 3'd1;
	localparam logic [2:0] V_QUEUE = 3'd2;
	localparam logic [2:0] V_PRIO = 3'd3;
	localparam logic [2:0] V_STACK = 3'd4;

	localparam logic [1:0] E_OK = 2'd0;
	localparam logic [1:0] E_EMPTY = 2'd1;
	localparam logic [1:0] E_FULL = 2'd2;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_EMPTY,
		OP_FULL
	} op_t;

	typedef struct packed {
		op_t op;
		logic clear;
		logic [PW-1:0] pt;
		logic [CW-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic [PW-1:0] pt;
		logic [SW-1:0] seq;
	} hent_t;

	function automatic logic [KW-1:0] pt_sum(input logic [PW-1:0] p);
		return KW'(p[PW-1:COORD_BITS]) + KW'(p[COORD_BITS-1:0]);
	endfunction
endpackage

// File: rtl/sqh_front.sv
`timescale 1ns / 1ps
// Classifies each beat against a shadow fill count and queues commands.
module sqh_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic func,
	input  logic start_case,
	input  logic [sqh_pkg::COORD_BITS-1:0] x_coord,
	input  logic [sqh_pkg::COORD_BITS-1:0] y_coord,
	output logic cmd_valid,
	input  logic cmd_ready,
	output sqh_pkg::cmd_t cmd
);
	localparam int QD = 2;
	sqh_pkg::cmd_t q_q [QD];
	logic [0:0] wp_q, rp_q;
	logic [1:0] n_q;
	logic [sqh_pkg::CW-1:0] cnt_q, base;
	sqh_pkg::cmd_t c;
	logic push, pop;

	assign in_ready = (n_q != 2'(QD));
	assign push = in_valid && in_ready;
	assign cmd_valid = (n_q != 2'd0);
	assign pop = cmd_valid && cmd_ready;
	assign cmd = q_q[rp_q];

	always_comb begin
		base = start_case ? '0 : cnt_q;
		c.clear = start_case;
		c.pt = {x_coord, y_coord};
		c.cnt = base;
		if (!func) begin
			c.op = (base >= sqh_pkg::CW'(sqh_pkg::DEPTH)) ? sqh_pkg::OP_FULL
				: sqh_pkg::OP_INSERT;
		end else begin
			c.op = (base == '0) ? sqh_pkg::OP_EMPTY : sqh_pkg::OP_REMOVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			n_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				q_q[wp_q] <= c;
				wp_q <= wp_q + 1'b1;
				unique case (c.op)
					sqh_pkg::OP_INSERT: cnt_q <= base + 1'b1;
					sqh_pkg::OP_REMOVE: cnt_q <= base - 1'b1;
					default: cnt_q <= base;
				endcase
			end
			if (pop) rp_q <= rp_q + 1'b1;
			n_q <= n_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sqh_pkg::CW'(sqh_pkg::DEPTH)) else $error("count overflow");
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 2'(QD)) else $error("queue overflow");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q == 2'(QD)) |-> !in_ready) else $error("ready when full");
`endif
endmodule

// File: rtl/sqh_back.sv
`timescale 1ns / 1ps
// Executes commands on the stack, ring and heap memories; one result per command.
module sqh_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  sqh_pkg::cmd_t cmd,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] verdict,
	output logic [1:0] error_code
);
	localparam int AW = sqh_pkg::AW;
	localparam int PW = sqh_pkg::PW;
	localparam int CW = sqh_pkg::CW;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_RDW, S_POP, S_UPR, S_UPW, S_DNL, S_DNR, S_DNC, S_DNW, S_DNF,
		S_RES
	} state_t;
	state_t st_q;

	logic [PW-1:0] stk_mem [sqh_pkg::DEPTH];
	logic [PW-1:0] fifo_mem [sqh_pkg::DEPTH];
	sqh_pkg::hent_t heap_mem [sqh_pkg::DEPTH];

	logic [AW-1:0] head_q, tail_q, sp_q;
	logic [sqh_pkg::SW-1:0] seq_q;
	logic [2:0] flags_q;
	logic [CW-1:0] n_q;
	sqh_pkg::cmd_t c_q;
	logic [PW-1:0] stk_rd_q, fifo_rd_q;
	sqh_pkg::hent_t h_rd_q, cur_q, tmp_q;
	logic [AW-1:0] i_q, j_q;
	logic [1:0] err_q;
	logic [2:0] res_verdict_q;
	logic [1:0] res_err_q;
	logic [2:0] v_next;

	// children of the current slot and the left child of the chosen child
	logic [CW-1:0] lc, rc, jl;

	// heap port: one read address, one write per cycle
	logic [AW-1:0] h_ra;
	logic h_we;
	logic [AW-1:0] h_wa;
	sqh_pkg::hent_t h_wd;

	function automatic logic earlier(input sqh_pkg::hent_t a, input sqh_pkg::hent_t b,
		input logic [sqh_pkg::SW-1:0] s);
		logic [sqh_pkg::KW-1:0] ka, kb;
		logic [sqh_pkg::SW-1:0] ga, gb;
		ka = sqh_pkg::pt_sum(a.pt);
		kb = sqh_pkg::pt_sum(b.pt);
		ga = s - a.seq;
		gb = s - b.seq;
		if (ka != kb) return ka > kb;
		return ga > gb;
	endfunction

	assign cmd_ready = (st_q == S_IDLE);
	assign lc = {i_q, 1'b1};
	assign rc = lc + 1'b1;
	assign jl = {j_q, 1'b1};

	always_ff @(posedge clk) begin
		stk_rd_q <= stk_mem[sp_q - 1'b1];
		fifo_rd_q <= fifo_mem[head_q];
		h_rd_q <= heap_mem[h_ra];
		if (h_we) heap_mem[h_wa] <= h_wd;
		if (st_q == S_IDLE && cmd_valid && cmd.op == sqh_pkg::OP_INSERT) begin
			stk_mem[cmd.clear ? '0 : sp_q] <= cmd.pt;
			fifo_mem[cmd.clear ? '0 : tail_q] <= cmd.pt;
		end
	end

	always_comb begin
		h_ra = i_q;
		h_we = 1'b0;
		h_wa = i_q;
		h_wd = cur_q;
		unique case (st_q)
			S_UPR: h_ra = (i_q - 1'b1) >> 1;
			S_UPW: begin
				h_we = 1'b1;
				h_wd = (i_q != '0 && earlier(cur_q, h_rd_q, seq_q)) ? h_rd_q : cur_q;
			end
			S_RD: h_ra = '0;
			S_RDW: h_ra = AW'(n_q - 1'b1);
			S_DNL: h_ra = AW'(lc);
			S_DNR: h_ra = AW'(rc);
			S_DNW: begin
				h_we = 1'b1;
				h_wd = (j_q != i_q) ? tmp_q : cur_q;
			end
			S_DNF: h_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			sp_q <= '0;
			seq_q <= '0;
			n_q <= '0;
			flags_q <= 3'b111;
			out_valid <= 1'b0;
			err_q <= sqh_pkg::E_OK;
			res_verdict_q <= sqh_pkg::V_UNSURE;
			res_err_q <= sqh_pkg::E_OK;
		end else begin
			if (st_q == S_RES && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (cmd_valid) begin
					c_q <= cmd;
					n_q <= cmd.cnt;
					if (cmd.clear) head_q <= '0;
					if (cmd.op == sqh_pkg::OP_EMPTY) flags_q <= 3'b000;
					else if (cmd.clear) flags_q <= 3'b111;
					if (cmd.op == sqh_pkg::OP_INSERT) begin
						sp_q <= (cmd.clear ? '0 : sp_q) + 1'b1;
						tail_q <= (cmd.clear ? '0 : tail_q) + 1'b1;
						seq_q <= (cmd.clear ? '0 : seq_q) + 1'b1;
					end else if (cmd.clear) begin
						sp_q <= '0; tail_q <= '0; seq_q <= '0;
					end
					unique case (cmd.op)
						sqh_pkg::OP_INSERT: begin
							err_q <= sqh_pkg::E_OK;
							cur_q <= '{pt: cmd.pt, seq: cmd.clear ? '0 : seq_q};
							i_q <= AW'(cmd.cnt);
							st_q <= S_UPR;
						end
						sqh_pkg::OP_REMOVE: begin
							err_q <= sqh_pkg::E_OK;
							st_q <= S_RD;
						end
						sqh_pkg::OP_EMPTY: begin
							err_q <= sqh_pkg::E_EMPTY;
							st_q <= S_RES;
						end
						default: begin
							err_q <= sqh_pkg::E_FULL;
							st_q <= S_RES;
						end
					endcase
				end
				S_UPR: st_q <= S_UPW;
				S_UPW: begin
					if (i_q != '0 && earlier(cur_q, h_rd_q, seq_q)) begin
						i_q <= (i_q - 1'b1) >> 1;
						st_q <= S_UPR;
					end else st_q <= S_RES;
				end
				S_RD: st_q <= S_RDW;
				S_RDW: begin
					// heap head and ring/stack reads arrive here
					flags_q <= flags_q & ~{(h_rd_q.pt != c_q.pt),
						(fifo_rd_q != c_q.pt), (stk_rd_q != c_q.pt)};
					head_q <= head_q + 1'b1;
					sp_q <= sp_q - 1'b1;
					n_q <= n_q - 1'b1;
					st_q <= S_POP;
				end
				S_POP: begin
					// last entry moves to the root and sinks
					cur_q <= h_rd_q;
					i_q <= '0;
					st_q <= (n_q > CW'(1)) ? S_DNL : S_DNF;
				end
				S_DNL: st_q <= S_DNR;
				S_DNR: begin
					if (earlier(h_rd_q, cur_q, seq_q)) begin
						tmp_q <= h_rd_q; j_q <= AW'(lc);
					end else begin
						tmp_q <= cur_q; j_q <= i_q;
					end
					st_q <= (rc < n_q) ? S_DNC : S_DNW;
				end
				S_DNC: begin
					if (earlier(h_rd_q, tmp_q, seq_q)) begin
						tmp_q <= h_rd_q; j_q <= AW'(rc);
					end
					st_q <= S_DNW;
				end
				S_DNW: begin
					// chosen child moves up into i and the sift descends; if none is chosen, cur is written at i
					if (j_q != i_q) begin
						i_q <= j_q;
						st_q <= (jl < n_q) ? S_DNL : S_DNF;
					end else st_q <= S_RES;
				end
				S_DNF: st_q <= S_RES;
				S_RES: if (!out_valid || out_ready) begin
					res_verdict_q <= v_next;
					res_err_q <= err_q;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		unique case (flags_q)
			3'b000: v_next = sqh_pkg::V_IMPOSSIBLE;
			3'b001: v_next = sqh_pkg::V_STACK;
			3'b010: v_next = sqh_pkg::V_QUEUE;
			3'b100: v_next = sqh_pkg::V_PRIO;
			default: v_next = sqh_pkg::V_UNSURE;
		endcase
	end
	assign verdict = res_verdict_q;
	assign error_code = res_err_q;

`ifndef SYNTHESIS
	a_one_res: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result lost");
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> st_q == S_IDLE) else $error("ready outside idle");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= sqh_pkg::CW'(sqh_pkg::DEPTH)) else $error("count range");
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable({verdict, error_code}))
		else $error("result changed while waiting");
`endif
endmodule

// File: rtl/stack_queue_heap_trace_checker.sv
`timescale 1ns / 1ps
// The back end works on one beat at a time and takes a new command only after
// it has registered the result of the last one.
// A two-entry command queue and a result register let the front accept while the back works.
// Reset: arst_n clears counters, pointers and flags at once; memories are not cleared.
module stack_queue_heap_trace_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic func,
	input  logic start_case,
	input  logic [sqh_pkg::COORD_BITS-1:0] x_coord,
	input  logic [sqh_pkg::COORD_BITS-1:0] y_coord,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] verdict,
	output logic [1:0] error_code
);
	logic cmd_valid, cmd_ready;
	sqh_pkg::cmd_t cmd;

	sqh_front u_front (.clk, .arst_n, .in_valid, .in_ready, .func, .start_case,
		.x_coord, .y_coord, .cmd_valid, .cmd_ready, .cmd);
	sqh_back u_back (.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.out_valid, .out_ready, .verdict, .error_code);
endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
	localparam bit F_INSERT = 1'b0;
	localparam bit F_REMOVE = 1'b1;
	localparam int FL_STACK = 0;
	localparam int FL_QUEUE = 1;
	localparam int FL_PRIO = 2;
	localparam int RAND_ITEMS = 640;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 100;

	typedef enum int {
		K_STACK,
		K_QUEUE,
		K_PRIO,
		K_NOISE
	} seq_kind_t;

	typedef struct {
		logic [2:0] verdict;
		logic [1:0] error_code;
	} verdict_t;

	typedef struct {
		bit f;
		bit sc;
		logic [sqh_pkg::COORD_BITS-1:0] x;
		logic [sqh_pkg::COORD_BITS-1:0] y;
		bit typed;
		logic [2:0] v;
		logic [1:0] e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic start_case = 1'b0;
	logic [sqh_pkg::COORD_BITS-1:0] x_coord = '0;
	logic [sqh_pkg::COORD_BITS-1:0] y_coord = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] verdict;
	logic [1:0] error_code;

	// shadow stores; the priority store keeps insertion order so the first max is the oldest
	logic [sqh_pkg::PW-1:0] stack_pts[$];
	logic [sqh_pkg::PW-1:0] ring_pts[$];
	logic [sqh_pkg::PW-1:0] prio_pts[$];
	logic [2:0] flags = 3'b111;
	verdict_t pending_verdicts[$];

	int tx_pct = 0;
	int rx_pct = 0;
	bit hold_req = 1'b0;
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int rand_items = 0;
	int full_drops = 0;
	int empty_removes = 0;
	int idle_count = 0;

	stack_queue_heap_trace_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.start_case(start_case),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict),
		.error_code(error_code)
	);

	always #5 clk = ~clk;

	function automatic int pt_sum_of(input logic [sqh_pkg::PW-1:0] p);
		return int'(p[sqh_pkg::PW-1:sqh_pkg::COORD_BITS]) +
			int'(p[sqh_pkg::COORD_BITS-1:0]);
	endfunction

	function automatic int prio_head_idx();
		int best;
		best = 0;
		for (int i = 1; i < prio_pts.size(); i++) begin
			if (pt_sum_of(prio_pts[i]) > pt_sum_of(prio_pts[best]))
				best = i;
		end
		return best;
	endfunction

	function automatic verdict_t predict_verdict(input bit f, input bit sc,
			input logic [sqh_pkg::COORD_BITS-1:0] x,
			input logic [sqh_pkg::COORD_BITS-1:0] y);
		verdict_t r;
		logic [sqh_pkg::PW-1:0] p;
		int hi;
		p = {x, y};
		r.error_code = sqh_pkg::E_OK;
		if (sc) begin
			stack_pts.delete();
			ring_pts.delete();
			prio_pts.delete();
			flags = 3'b111;
		end
		if (f == F_INSERT) begin
			if (stack_pts.size() >= sqh_pkg::DEPTH) begin
				r.error_code = sqh_pkg::E_FULL;
			end else begin
				stack_pts.push_back(p);
				ring_pts.push_back(p);
				prio_pts.push_back(p);
			end
		end else if (stack_pts.size() == 0) begin
			flags = 3'b000;
			r.error_code = sqh_pkg::E_EMPTY;
		end else begin
			hi = prio_head_idx();
			if (prio_pts[hi] != p)
				flags[FL_PRIO] = 1'b0;
			prio_pts.delete(hi);
			if (ring_pts.pop_front() != p)
				flags[FL_QUEUE] = 1'b0;
			if (stack_pts.pop_back() != p)
				flags[FL_STACK] = 1'b0;
		end
		case (flags)
			3'b000: r.verdict = sqh_pkg::V_IMPOSSIBLE;
			3'b001: r.verdict = sqh_pkg::V_STACK;
			3'b010: r.verdict = sqh_pkg::V_QUEUE;
			3'b100: r.verdict = sqh_pkg::V_PRIO;
			default: r.verdict = sqh_pkg::V_UNSURE;
		endcase
		return r;
	endfunction

	task automatic send_item(input bit f, input bit sc,
			input logic [sqh_pkg::COORD_BITS-1:0] x,
			input logic [sqh_pkg::COORD_BITS-1:0] y, input bit typed, input logic [2:0] tv,
			input logic [1:0] te);
		verdict_t r;
		@(negedge clk);
		while (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		start_case <= sc;
		x_coord <= x;
		y_coord <= y;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = predict_verdict(f, sc, x, y);
		if (typed) begin
			r.verdict = tv;
			r.error_code = te;
		end
		if (r.error_code == sqh_pkg::E_FULL)
			full_drops++;
		if (r.error_code == sqh_pkg::E_EMPTY)
			empty_removes++;
		pending_verdicts.push_back(r);
		items_sent++;
	endtask

	task automatic send_checked(input bit f, input bit sc,
			input logic [sqh_pkg::COORD_BITS-1:0] x,
			input logic [sqh_pkg::COORD_BITS-1:0] y);
		send_item(f, sc, x, y, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// one well-formed trace for a chosen structure, with some noise mixed in
	task automatic rand_sequence();
		seq_kind_t kind;
		int len;
		bit narrow;
		bit f;
		bit sc;
		logic [sqh_pkg::COORD_BITS-1:0] x;
		logic [sqh_pkg::COORD_BITS-1:0] y;
		logic [sqh_pkg::PW-1:0] p;
		kind = seq_kind_t'($urandom_range(0, 3));
		len = $urandom_range(2, 16);
		narrow = 1'($urandom_range(0, 1));
		for (int i = 0; i < len; i++) begin
			sc = (i == 0) || (kind == K_NOISE && $urandom_range(0, 9) == 0);
			x = narrow ? sqh_pkg::COORD_BITS'($urandom_range(0, 3))
				: sqh_pkg::COORD_BITS'($urandom_range(0, 127));
			y = narrow ? sqh_pkg::COORD_BITS'($urandom_range(0, 3))
				: sqh_pkg::COORD_BITS'($urandom_range(0, 127));
			if (kind == K_NOISE)
				f = 1'($urandom_range(0, 1));
			else
				f = (!sc && stack_pts.size() > 0 && $urandom_range(0, 99) < 45) ||
					$urandom_range(0, 29) == 0;
			if (f == F_REMOVE && !sc && stack_pts.size() > 0 && kind != K_NOISE &&
					$urandom_range(0, 14) != 0) begin
				case (kind)
					K_STACK: p = stack_pts[$];
					K_QUEUE: p = ring_pts[0];
					default: p = prio_pts[prio_head_idx()];
				endcase
				x = p[sqh_pkg::PW-1:sqh_pkg::COORD_BITS];
				y = p[sqh_pkg::COORD_BITS-1:0];
			end
			send_checked(f, sc, x, y);
			rand_items++;
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready <= !(rx_pct > 0 && $urandom_range(0, 99) < rx_pct);
		end
	end

	// result checker and stall watchdog
	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected beat verdict=%0d error_code=%0d", $time,
					verdict, error_code);
				errors++;
			end else begin
				exp_v = pending_verdicts.pop_front();
				if (verdict !== exp_v.verdict) begin
					$display("%0t: verdict expected %0d actual %0d", $time,
						exp_v.verdict, verdict);
					errors++;
				end
				if (error_code !== exp_v.error_code) begin
					$display("%0t: error_code expected %0d actual %0d", $time,
						exp_v.error_code, error_code);
					errors++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count == STALL_LIMIT) begin
			$display("%0t: timeout, no beat for %0d cycles", $time, STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	row_t rows[] = '{
		'{F_REMOVE, 1'b0, 7'd5, 7'd5, 1'b1, sqh_pkg::V_IMPOSSIBLE, sqh_pkg::E_EMPTY},
		'{F_INSERT, 1'b1, 7'd0, 7'd0, 1'b1, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_INSERT, 1'b0, 7'd127, 7'd127, 1'b1, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_INSERT, 1'b0, 7'd127, 7'd0, 1'b1, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_REMOVE, 1'b0, 7'd127, 7'd127, 1'b1, sqh_pkg::V_PRIO, sqh_pkg::E_OK},
		'{F_REMOVE, 1'b0, 7'd0, 7'd0, 1'b1, sqh_pkg::V_IMPOSSIBLE, sqh_pkg::E_OK},
		'{F_REMOVE, 1'b0, 7'd127, 7'd0, 1'b1, sqh_pkg::V_IMPOSSIBLE, sqh_pkg::E_OK},
		'{F_REMOVE, 1'b0, 7'd1, 7'd1, 1'b1, sqh_pkg::V_IMPOSSIBLE, sqh_pkg::E_EMPTY},
		// equal sums: the oldest point must leave the heap first
		'{F_INSERT, 1'b1, 7'd10, 7'd20, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_INSERT, 1'b0, 7'd20, 7'd10, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_INSERT, 1'b0, 7'd30, 7'd0, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_REMOVE, 1'b0, 7'd10, 7'd20, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_REMOVE, 1'b0, 7'd20, 7'd10, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_REMOVE, 1'b0, 7'd30, 7'd0, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_INSERT, 1'b1, 7'd1, 7'd2, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_INSERT, 1'b0, 7'd3, 7'd4, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_REMOVE, 1'b0, 7'd3, 7'd4, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_REMOVE, 1'b0, 7'd1, 7'd2, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_INSERT, 1'b1, 7'd5, 7'd5, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_INSERT, 1'b0, 7'd9, 7'd0, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_INSERT, 1'b0, 7'd0, 7'd1, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_REMOVE, 1'b0, 7'd5, 7'd5, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_REMOVE, 1'b0, 7'd0, 7'd1, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK},
		'{F_REMOVE, 1'b0, 7'd9, 7'd0, 1'b0, sqh_pkg::V_UNSURE, sqh_pkg::E_OK}
	};

	initial begin
		bit held;
		bit paused;
		held = 1'b0;
		paused = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send_item(rows[i].f, rows[i].sc, rows[i].x, rows[i].y, rows[i].typed,
				rows[i].v, rows[i].e);

		while (rand_items < RAND_ITEMS) begin
			case ((rand_items * 4) / RAND_ITEMS)
				0: begin tx_pct = 0; rx_pct = 0; end
				1: begin tx_pct = 72; rx_pct = 0; end
				2: begin tx_pct = 0; rx_pct = 72; end
				default: begin tx_pct = 28; rx_pct = 28; end
			endcase
			if (!held && rand_items >= RAND_ITEMS / 8) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			if (!paused && rand_items >= (RAND_ITEMS * 5) / 8) begin
				drain();
				paused = 1'b1;
			end
			rand_sequence();
		end

		// a closing burst of unrelated inserts and removes with no idling
		tx_pct = 0;
		rx_pct = 0;
		for (int i = 0; i < 24; i++)
			send_checked(1'($urandom_range(0, 1)), 1'b0,
				sqh_pkg::COORD_BITS'($urandom_range(0, 127)),
				sqh_pkg::COORD_BITS'($urandom_range(0, 127)));

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d items (%0d random) and %0d results,", items_sent,
			rand_items, results_seen);
		$display("with %0d full-store drops and %0d removes on empty.", full_drops,
			empty_removes);
		if (errors == 0 && pending_verdicts.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

// File: files.f
rtl/sqh_pkg.sv
rtl/sqh_front.sv
rtl/sqh_back.sv
rtl/stack_queue_heap_trace_checker.sv
verif/tb.sv
